// ===== rtl/core/afm_pkg.sv =====
// ----------------------------------------------------------------------------
// afm_pkg
// shared widths, register indexes and reset values for the analog fault monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afm_pkg;

    // sample and register widths
    localparam int SAMPLE_W = 12;
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    // signed excess accumulator width
    localparam int ACC_W = 17;

    // default tuning values
    localparam int DEF_TEMP_RELEASE_LEVEL = 610;
    localparam int DEF_VOLT_DEBOUNCE = 10;
    localparam int DEF_TEMP_DEBOUNCE = 5000;
    localparam int DEF_CURRENT_BUDGET = 150;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_VOLT_HIGH_TRIP    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VOLT_HIGH_RELEASE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VOLT_LOW_TRIP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_VOLT_LOW_RELEASE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CURR_TRIP_LEVEL   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CURR_LIMIT_LEVEL  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_LOW_TRIP     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CURRENT_OFFSET    = 3'd7;

    // register reset values
    localparam logic [SAMPLE_W-1:0] RST_VOLT_HIGH_TRIP    = 12'd1636;
    localparam logic [SAMPLE_W-1:0] RST_VOLT_HIGH_RELEASE = 12'd1596;
    localparam logic [SAMPLE_W-1:0] RST_VOLT_LOW_TRIP     = 12'd684;
    localparam logic [SAMPLE_W-1:0] RST_VOLT_LOW_RELEASE  = 12'd725;
    localparam logic [SAMPLE_W-1:0] RST_CURR_TRIP_LEVEL   = 12'd1096;
    localparam logic [SAMPLE_W-1:0] RST_CURR_LIMIT_LEVEL  = 12'd958;
    localparam logic [SAMPLE_W-1:0] RST_TEMP_LOW_TRIP     = 12'd500;
    localparam logic [SAMPLE_W-1:0] RST_CURRENT_OFFSET    = 12'd0;

    // one result transaction
    typedef struct packed {
        logic                over_voltage;
        logic                under_voltage;
        logic                over_temperature;
        logic                over_current;
        logic                restrict_duty;
        logic [SAMPLE_W-1:0] peak_current;
    } t_result;

endpackage

// ===== rtl/core/afm_sample_if.sv =====
// ----------------------------------------------------------------------------
// afm_sample_if
// valid/ready channel carrying one tick of converter samples
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface afm_sample_if
    import afm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] voltage_sample;
    logic [SAMPLE_W-1:0] current_sample;
    logic [SAMPLE_W-1:0] temperature_sample;

    modport source (
        output valid, voltage_sample, current_sample, temperature_sample,
        input  ready
    );
    modport sink (
        input  valid, voltage_sample, current_sample, temperature_sample,
        output ready
    );
endinterface

// ===== rtl/core/afm_status_if.sv =====
// ----------------------------------------------------------------------------
// afm_status_if
// valid/ready channel carrying the alarm flags and peak current of one tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface afm_status_if
    import afm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                over_voltage;
    logic                under_voltage;
    logic                over_temperature;
    logic                over_current;
    logic                restrict_duty;
    logic [SAMPLE_W-1:0] peak_current;

    modport source (
        output valid, over_voltage, under_voltage, over_temperature, over_current,
               restrict_duty, peak_current,
        input  ready
    );
    modport sink (
        input  valid, over_voltage, under_voltage, over_temperature, over_current,
               restrict_duty, peak_current,
        output ready
    );
endinterface

// ===== rtl/core/analog_fault_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// path: an accepted sample transaction is held in the sample register, then
//   its status goes to the status register; one transaction per cycle while
//   the status channel does not stall, set by the state update between them
// reset: synchronous active-low i_rst_n clears all alarms, counters, the
//   accumulator and the peak, and loads the default threshold registers
// ----------------------------------------------------------------------------
// analog_fault_monitor_unit
// per-tick supervision of bus voltage, current and temperature samples
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module analog_fault_monitor_unit
    import afm_pkg::*;
#(
    parameter int TEMP_RELEASE_LEVEL = DEF_TEMP_RELEASE_LEVEL,
    parameter int VOLT_DEBOUNCE      = DEF_VOLT_DEBOUNCE,
    parameter int TEMP_DEBOUNCE      = DEF_TEMP_DEBOUNCE,
    parameter int CURRENT_BUDGET     = DEF_CURRENT_BUDGET
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_addr,
    input  logic [SAMPLE_W-1:0]  i_cfg_wdata,
    // sample transactions in, status transactions out
    afm_sample_if.sink           i_sample,
    afm_status_if.source         o_status
);

    // debounce counters reach at most debounce + 1 before clearing
    localparam int VC_W = $clog2(VOLT_DEBOUNCE + 2);
    localparam int TC_W = $clog2(TEMP_DEBOUNCE + 2);

    // accumulator math is done one bit wider so a clamp can be detected
    localparam int AX_W = ACC_W + 1;
    localparam logic signed [AX_W-1:0] ACC_MAX = AX_W'((1 << (ACC_W - 1)) - 1);
    localparam logic signed [AX_W-1:0] ACC_MIN = -AX_W'(1 << (ACC_W - 1));
    localparam logic signed [AX_W-1:0] BUDGET  = AX_W'(CURRENT_BUDGET);

    localparam logic [VC_W-1:0]     VOLT_DEB  = VC_W'(VOLT_DEBOUNCE);
    localparam logic [TC_W-1:0]     TEMP_DEB  = TC_W'(TEMP_DEBOUNCE);
    localparam logic [SAMPLE_W-1:0] TEMP_REL  = SAMPLE_W'(TEMP_RELEASE_LEVEL);

    // ------------------------------------------------------------------
    // threshold registers
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] r_volt_high_trip, r_volt_high_release;
    logic [SAMPLE_W-1:0] r_volt_low_trip, r_volt_low_release;
    logic [SAMPLE_W-1:0] r_curr_trip_level, r_curr_limit_level;
    logic [SAMPLE_W-1:0] r_temp_low_trip, r_current_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_high_trip    <= RST_VOLT_HIGH_TRIP;
            r_volt_high_release <= RST_VOLT_HIGH_RELEASE;
            r_volt_low_trip     <= RST_VOLT_LOW_TRIP;
            r_volt_low_release  <= RST_VOLT_LOW_RELEASE;
            r_curr_trip_level   <= RST_CURR_TRIP_LEVEL;
            r_curr_limit_level  <= RST_CURR_LIMIT_LEVEL;
            r_temp_low_trip     <= RST_TEMP_LOW_TRIP;
            r_current_offset    <= RST_CURRENT_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_VOLT_HIGH_TRIP:    r_volt_high_trip    <= i_cfg_wdata;
                REG_VOLT_HIGH_RELEASE: r_volt_high_release <= i_cfg_wdata;
                REG_VOLT_LOW_TRIP:     r_volt_low_trip     <= i_cfg_wdata;
                REG_VOLT_LOW_RELEASE:  r_volt_low_release  <= i_cfg_wdata;
                REG_CURR_TRIP_LEVEL:   r_curr_trip_level   <= i_cfg_wdata;
                REG_CURR_LIMIT_LEVEL:  r_curr_limit_level  <= i_cfg_wdata;
                REG_TEMP_LOW_TRIP:     r_temp_low_trip     <= i_cfg_wdata;
                REG_CURRENT_OFFSET:    r_current_offset    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake: sample register feeds status register
    // ------------------------------------------------------------------
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_volt, r_curr, r_temp;
    logic                r_out_valid;
    t_result             r_res;
    logic                in_take;
    logic                advance;

    // the update fires when the sample register holds a transaction and the
    // status register is empty or being drained this cycle
    assign advance        = r_in_valid && (!r_out_valid || o_status.ready);
    assign i_sample.ready = !r_in_valid || advance;
    assign in_take        = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_volt <= i_sample.voltage_sample;
            r_curr <= i_sample.current_sample;
            r_temp <= i_sample.temperature_sample;
        end
    end

    // ------------------------------------------------------------------
    // monitor state
    // ------------------------------------------------------------------
    logic                    r_ov_alarm, r_uv_alarm, r_ot_alarm, r_oc_alarm;
    logic [VC_W-1:0]         r_ov_count, r_uv_count;
    logic [TC_W-1:0]         r_ot_trip_count, r_ot_release_count;
    logic signed [ACC_W-1:0] r_acc;
    logic [SAMPLE_W-1:0]     r_peak;

    logic                    n_ov_alarm, n_uv_alarm, n_ot_alarm, n_oc_alarm;
    logic [VC_W-1:0]         n_ov_count, n_uv_count;
    logic [TC_W-1:0]         n_ot_trip_count, n_ot_release_count;
    logic signed [ACC_W-1:0] n_acc;
    logic [SAMPLE_W-1:0]     n_peak;
    logic                    n_restrict;

    // helper values
    logic [VC_W-1:0]         ov_inc, uv_inc;
    logic [TC_W-1:0]         ot_trip_inc, ot_rel_inc;
    logic [SAMPLE_W-1:0]     curr_corr;
    logic [SAMPLE_W-1:0]     curr_excess;
    logic signed [AX_W-1:0]  acc_ext, acc_sum, acc_add, acc_dec;

    assign ov_inc      = r_ov_count + VC_W'(1);
    assign uv_inc      = r_uv_count + VC_W'(1);
    assign ot_trip_inc = r_ot_trip_count + TC_W'(1);
    assign ot_rel_inc  = r_ot_release_count + TC_W'(1);

    // offset removal with floor at zero
    assign curr_corr   = (r_curr > r_current_offset) ? (r_curr - r_current_offset)
                                                     : '0;
    assign curr_excess = curr_corr - r_curr_trip_level;

    assign acc_ext = AX_W'(r_acc);
    assign acc_sum = acc_ext + signed'({1'b0, {(AX_W - SAMPLE_W - 1){1'b0}}, curr_excess});
    // excess is never negative, so only the upper bound can be hit
    assign acc_add = (acc_sum > ACC_MAX) ? ACC_MAX : acc_sum;
    assign acc_dec = ((acc_ext - AX_W'(1)) < ACC_MIN) ? ACC_MIN : (acc_ext - AX_W'(1));

    always_comb begin
        n_ov_alarm         = r_ov_alarm;
        n_uv_alarm         = r_uv_alarm;
        n_ot_alarm         = r_ot_alarm;
        n_oc_alarm         = r_oc_alarm;
        n_ov_count         = r_ov_count;
        n_uv_count         = r_uv_count;
        n_ot_trip_count    = r_ot_trip_count;
        n_ot_release_count = r_ot_release_count;
        n_acc              = r_acc;
        n_peak             = r_peak;
        n_restrict         = 1'b0;

        // over-voltage: consecutive debounce, immediate release
        if (r_ov_alarm) begin
            if (r_volt < r_volt_high_release) begin
                n_ov_alarm = 1'b0;
            end
        end else if (r_volt > r_volt_high_trip) begin
            if (ov_inc > VOLT_DEB) begin
                n_ov_count = '0;
                n_ov_alarm = 1'b1;
            end else begin
                n_ov_count = ov_inc;
            end
        end else begin
            n_ov_count = '0;
        end

        // under-voltage: mirror of the above
        if (r_uv_alarm) begin
            if (r_volt > r_volt_low_release) begin
                n_uv_alarm = 1'b0;
            end
        end else if (r_volt < r_volt_low_trip) begin
            if (uv_inc > VOLT_DEB) begin
                n_uv_count = '0;
                n_uv_alarm = 1'b1;
            end else begin
                n_uv_count = uv_inc;
            end
        end else begin
            n_uv_count = '0;
        end

        // over-temperature: release count is cumulative, never cleared
        // by ticks at or below the release level
        if (r_ot_alarm) begin
            if (r_temp > TEMP_REL) begin
                if (ot_rel_inc > TEMP_DEB) begin
                    n_ot_release_count = '0;
                    n_ot_alarm         = 1'b0;
                end else begin
                    n_ot_release_count = ot_rel_inc;
                end
            end
        end else if (r_temp < r_temp_low_trip) begin
            if (ot_trip_inc > TEMP_DEB) begin
                n_ot_trip_count = '0;
                n_ot_alarm      = 1'b1;
            end else begin
                n_ot_trip_count = ot_trip_inc;
            end
        end else begin
            n_ot_trip_count = '0;
        end

        // current: restrict above limit; there, integrate excess above trip or else step down
        if (curr_corr > r_curr_limit_level) begin
            n_restrict = 1'b1;
            if (curr_corr > r_curr_trip_level) begin
                if (acc_add > BUDGET) begin
                    n_acc      = '0;
                    n_oc_alarm = 1'b1;
                end else begin
                    n_acc = acc_add[ACC_W-1:0];
                end
            end else begin
                n_acc = acc_dec[ACC_W-1:0];
            end
        end else begin
            // leak toward zero, a negative value snaps to zero
            if (r_acc > ACC_W'(0)) begin
                n_acc = r_acc - ACC_W'(1);
            end else begin
                n_acc = '0;
            end
            n_oc_alarm = 1'b0;
        end

        if (curr_corr > r_peak) begin
            n_peak = curr_corr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov_alarm         <= 1'b0;
            r_uv_alarm         <= 1'b0;
            r_ot_alarm         <= 1'b0;
            r_oc_alarm         <= 1'b0;
            r_ov_count         <= '0;
            r_uv_count         <= '0;
            r_ot_trip_count    <= '0;
            r_ot_release_count <= '0;
            r_acc              <= '0;
            r_peak             <= '0;
        end else if (advance) begin
            r_ov_alarm         <= n_ov_alarm;
            r_uv_alarm         <= n_uv_alarm;
            r_ot_alarm         <= n_ot_alarm;
            r_oc_alarm         <= n_oc_alarm;
            r_ov_count         <= n_ov_count;
            r_uv_count         <= n_uv_count;
            r_ot_trip_count    <= n_ot_trip_count;
            r_ot_release_count <= n_ot_release_count;
            r_acc              <= n_acc;
            r_peak             <= n_peak;
        end
    end

    // ------------------------------------------------------------------
    // status register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !o_status.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res.over_voltage     <= n_ov_alarm;
            r_res.under_voltage    <= n_uv_alarm;
            r_res.over_temperature <= n_ot_alarm;
            r_res.over_current     <= n_oc_alarm;
            r_res.restrict_duty    <= n_restrict;
            r_res.peak_current     <= n_peak;
        end
    end

    assign o_status.valid            = r_out_valid;
    assign o_status.over_voltage     = r_res.over_voltage;
    assign o_status.under_voltage    = r_res.under_voltage;
    assign o_status.over_temperature = r_res.over_temperature;
    assign o_status.over_current     = r_res.over_current;
    assign o_status.restrict_duty    = r_res.restrict_duty;
    assign o_status.peak_current     = r_res.peak_current;

endmodule

// ===== verif/tb_analog_fault_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// tb_analog_fault_monitor_unit
// self-checking bench for the analog fault monitor: drives sample ticks through
// the valid/ready channel, keeps its own model of every alarm, counter, the
// excess accumulator and the peak hold, and compares each status transaction
// field by field. phases change the thresholds while idle and vary the stalls
// on both channels; runs of cold ticks exercise the temperature debounce and
// runs above a zero limit drive the current accumulator negative
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_analog_fault_monitor_unit;
    import afm_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 400;
    localparam int FULL_SCALE    = (1 << SAMPLE_W) - 1;
    localparam int ACC_LO        = -(1 << (ACC_W - 1));
    localparam int ACC_HI        = (1 << (ACC_W - 1)) - 1;
    localparam int TEMP_RELEASE  = DEF_TEMP_RELEASE_LEVEL;
    localparam int VOLT_DEBOUNCE = DEF_VOLT_DEBOUNCE;
    localparam int TEMP_DEBOUNCE = DEF_TEMP_DEBOUNCE;
    localparam int BUDGET        = DEF_CURRENT_BUDGET;

    // one tick of converter samples
    typedef struct packed {
        logic [SAMPLE_W-1:0] voltage;
        logic [SAMPLE_W-1:0] current;
        logic [SAMPLE_W-1:0] temperature;
    } t_tick;

    // sample bands used to build runs of related ticks
    typedef enum int {VB_HIGH, VB_LOW, VB_MID, VB_NEAR_RELEASE, VB_ANY} t_volt_band;
    typedef enum int {TB_COLD, TB_MID, TB_WARM, TB_ANY} t_temp_band;
    typedef enum int {CB_ZERO, CB_NORMAL, CB_LIMITED, CB_EXCESS, CB_ANY} t_curr_band;
    typedef enum int {THERMAL_FREE, THERMAL_COLD, THERMAL_MOSTLY_WARM} t_thermal_plan;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_addr;
    logic [SAMPLE_W-1:0]  i_cfg_wdata;

    afm_sample_if sample_ch ();
    afm_status_if status_ch ();

    analog_fault_monitor_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (sample_ch),
        .o_status    (status_ch)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_tick   pending_ticks[$];     // ticks waiting to be offered
    t_result expected_status[$];   // predicted status, oldest first
    int      mismatch_count;
    int      cycle_count;
    int      sender_gap_pct;
    int      receiver_stall_pct;

    // long receiver hold-off, served by its own counter process
    int      hold_requests;
    int      holds_served;
    int      hold_left;

    // generator run state
    t_volt_band    volt_band;
    t_temp_band    temp_band;
    t_curr_band    curr_band;
    int            volt_left;
    int            temp_left;
    int            curr_left;
    t_thermal_plan thermal_plan;
    bit            hold_limited_current;   // keep current between limit and trip
    int            peak_cap;               // ceiling on the corrected current

    // threshold copy, written alongside every register write
    logic [SAMPLE_W-1:0] thresholds [NUM_REGS];

    // monitor state as the block should hold it
    logic                     ov_alarm;
    logic                     uv_alarm;
    logic                     ot_alarm;
    logic                     oc_alarm;
    logic [3:0]               ov_run;
    logic [3:0]               uv_run;
    logic [12:0]              cold_run;
    logic [12:0]              warm_total;
    logic signed [ACC_W-1:0]  excess_accum;
    logic [SAMPLE_W-1:0]      peak_hold;

    // ------------------------------------------------------------------------
    // status prediction for one accepted tick
    // ------------------------------------------------------------------------
    function automatic t_result predict_status(t_tick s);
        t_result             r;
        logic [SAMPLE_W-1:0] corr;
        int                  acc_next;
        logic                duty;

        // over-voltage: debounce on consecutive high ticks, clear at once
        if (ov_alarm) begin
            if (s.voltage < thresholds[REG_VOLT_HIGH_RELEASE]) ov_alarm = 1'b0;
        end else if (s.voltage > thresholds[REG_VOLT_HIGH_TRIP]) begin
            ov_run = ov_run + 1'b1;
            if (ov_run > VOLT_DEBOUNCE) begin
                ov_run   = '0;
                ov_alarm = 1'b1;
            end
        end else begin
            ov_run = '0;
        end

        // under-voltage, mirror image
        if (uv_alarm) begin
            if (s.voltage > thresholds[REG_VOLT_LOW_RELEASE]) uv_alarm = 1'b0;
        end else if (s.voltage < thresholds[REG_VOLT_LOW_TRIP]) begin
            uv_run = uv_run + 1'b1;
            if (uv_run > VOLT_DEBOUNCE) begin
                uv_run   = '0;
                uv_alarm = 1'b1;
            end
        end else begin
            uv_run = '0;
        end

        // over-temperature: consecutive cold ticks set, a cumulative count of warm ticks clears
        if (ot_alarm) begin
            if (s.temperature > TEMP_RELEASE) begin
                warm_total = warm_total + 1'b1;
                if (warm_total > TEMP_DEBOUNCE) begin
                    warm_total = '0;
                    ot_alarm   = 1'b0;
                end
            end
        end else if (s.temperature < thresholds[REG_TEMP_LOW_TRIP]) begin
            cold_run = cold_run + 1'b1;
            if (cold_run > TEMP_DEBOUNCE) begin
                cold_run = '0;
                ot_alarm = 1'b1;
            end
        end else begin
            cold_run = '0;
        end

        // current: offset removal with a floor at zero
        corr = (s.current > thresholds[REG_CURRENT_OFFSET]) ?
               s.current - thresholds[REG_CURRENT_OFFSET] : '0;
        if (corr > thresholds[REG_CURR_LIMIT_LEVEL]) begin
            duty = 1'b1;
            if (corr > thresholds[REG_CURR_TRIP_LEVEL]) begin
                acc_next = int'(excess_accum) + int'(corr)
                           - int'(thresholds[REG_CURR_TRIP_LEVEL]);
            end else begin
                acc_next = int'(excess_accum) - 1;
            end
            if (acc_next < ACC_LO) acc_next = ACC_LO;
            if (acc_next > ACC_HI) acc_next = ACC_HI;
            if (corr > thresholds[REG_CURR_TRIP_LEVEL] && acc_next > BUDGET) begin
                acc_next = 0;
                oc_alarm = 1'b1;
            end
        end else begin
            // leak toward zero, a negative value snaps back to zero
            acc_next = (excess_accum >= 1) ? int'(excess_accum) - 1 : 0;
            duty     = 1'b0;
            oc_alarm = 1'b0;
        end
        excess_accum = acc_next[ACC_W-1:0];

        if (corr > peak_hold) peak_hold = corr;

        r.over_voltage     = ov_alarm;
        r.under_voltage    = uv_alarm;
        r.over_temperature = ot_alarm;
        r.over_current     = oc_alarm;
        r.restrict_duty    = duty;
        r.peak_current     = peak_hold;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sample picking within a band
    // ------------------------------------------------------------------------
    function automatic int clip_sample(int x);
        if (x < 0) return 0;
        if (x > FULL_SCALE) return FULL_SCALE;
        return x;
    endfunction

    function automatic int above_level(int lvl);
        return (lvl >= FULL_SCALE) ? FULL_SCALE : int'($urandom_range(FULL_SCALE, lvl + 1));
    endfunction

    function automatic int below_level(int lvl);
        return (lvl <= 0) ? 0 : int'($urandom_range(lvl - 1, 0));
    endfunction

    function automatic int pick_voltage(t_volt_band b);
        int rel;
        case (b)
            VB_HIGH: return above_level(thresholds[REG_VOLT_HIGH_TRIP]);
            VB_LOW:  return below_level(thresholds[REG_VOLT_LOW_TRIP]);
            VB_MID: begin
                return $urandom_range(thresholds[REG_VOLT_HIGH_TRIP],
                                      thresholds[REG_VOLT_LOW_TRIP]);
            end
            VB_NEAR_RELEASE: begin
                rel = $urandom_range(1) ? thresholds[REG_VOLT_HIGH_RELEASE]
                                        : thresholds[REG_VOLT_LOW_RELEASE];
                return clip_sample(rel + int'($urandom_range(6)) - 3);
            end
            default: return $urandom_range(FULL_SCALE);
        endcase
    endfunction

    function automatic int pick_temperature(t_temp_band b);
        case (b)
            TB_COLD: return below_level(thresholds[REG_TEMP_LOW_TRIP]);
            TB_MID:  return $urandom_range(TEMP_RELEASE, thresholds[REG_TEMP_LOW_TRIP]);
            TB_WARM: return above_level(TEMP_RELEASE);
            default: return $urandom_range(FULL_SCALE);
        endcase
    endfunction

    // returns a raw sample whose corrected value falls in the band, unless peak_cap or full scale cuts it
    function automatic int pick_current(t_curr_band b);
        int lim;
        int trip;
        int off;
        int corr;
        lim  = thresholds[REG_CURR_LIMIT_LEVEL];
        trip = thresholds[REG_CURR_TRIP_LEVEL];
        off  = thresholds[REG_CURRENT_OFFSET];
        case (b)
            CB_ZERO:    return $urandom_range(off, 0);
            CB_NORMAL:  corr = $urandom_range(lim, 0);
            CB_LIMITED: corr = (trip > lim) ? int'($urandom_range(trip, lim + 1)) : lim + 1;
            CB_EXCESS:  corr = ((lim > trip) ? lim : trip) + int'($urandom_range(60, 1));
            default:    corr = $urandom_range(FULL_SCALE);
        endcase
        if (corr > peak_cap) corr = peak_cap;
        return clip_sample(corr + off);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_tick(int v, int c, int t);
        t_tick tk;
        tk.voltage     = SAMPLE_W'(v);
        tk.current     = SAMPLE_W'(c);
        tk.temperature = SAMPLE_W'(t);
        pending_ticks.push_back(tk);
    endtask

    // runs of ticks in one band per field, so debounce counts build up,
    // with a sprinkling of fully random ticks as noise
    task automatic queue_random_ticks(int count);
        t_tick tk;
        for (int k = 0; k < count; k++) begin
            if (volt_left == 0) begin
                volt_band = t_volt_band'($urandom_range(VB_ANY));
                volt_left = $urandom_range(16, 1);
            end
            if (temp_left == 0) begin
                temp_band = t_temp_band'($urandom_range(TB_ANY));
                temp_left = $urandom_range(16, 1);
            end
            if (curr_left == 0) begin
                curr_band = t_curr_band'($urandom_range(CB_ANY));
                curr_left = $urandom_range(12, 1);
            end
            volt_left--;
            temp_left--;
            curr_left--;
            case (thermal_plan)
                THERMAL_COLD: temp_band = TB_COLD;
                THERMAL_MOSTLY_WARM: begin
                    temp_band = ($urandom_range(99) < 80) ? TB_WARM
                                                          : t_temp_band'($urandom_range(TB_MID));
                end
                default: ;
            endcase
            if (hold_limited_current) curr_band = CB_LIMITED;

            if (thermal_plan == THERMAL_FREE && !hold_limited_current &&
                $urandom_range(99) < 8) begin
                tk.voltage     = SAMPLE_W'($urandom_range(FULL_SCALE));
                tk.current     = SAMPLE_W'($urandom_range(FULL_SCALE));
                tk.temperature = SAMPLE_W'($urandom_range(FULL_SCALE));
            end else begin
                tk.voltage     = SAMPLE_W'(pick_voltage(volt_band));
                tk.current     = SAMPLE_W'(pick_current(curr_band));
                tk.temperature = SAMPLE_W'(pick_temperature(temp_band));
            end
            pending_ticks.push_back(tk);
        end
    endtask

    // register write, one per clock, model copy kept in step
    task automatic write_threshold(logic [REG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        thresholds[idx] = val;
    endtask

    task automatic load_thresholds(int v_hi, int v_hi_rel, int v_lo, int v_lo_rel,
                                   int c_trip, int c_lim, int t_trip, int c_off);
        write_threshold(REG_VOLT_HIGH_TRIP,    SAMPLE_W'(v_hi));
        write_threshold(REG_VOLT_HIGH_RELEASE, SAMPLE_W'(v_hi_rel));
        write_threshold(REG_VOLT_LOW_TRIP,     SAMPLE_W'(v_lo));
        write_threshold(REG_VOLT_LOW_RELEASE,  SAMPLE_W'(v_lo_rel));
        write_threshold(REG_CURR_TRIP_LEVEL,   SAMPLE_W'(c_trip));
        write_threshold(REG_CURR_LIMIT_LEVEL,  SAMPLE_W'(c_lim));
        write_threshold(REG_TEMP_LOW_TRIP,     SAMPLE_W'(t_trip));
        write_threshold(REG_CURRENT_OFFSET,    SAMPLE_W'(c_off));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_thresholds();
        int v_hi;
        int v_lo;
        v_hi = $urandom_range(3500, 1200);
        v_lo = $urandom_range(1000, 200);
        load_thresholds(v_hi, v_hi - int'($urandom_range(120)), v_lo,
                        v_lo + int'($urandom_range(120)), $urandom_range(2500, 800),
                        $urandom_range(2500, 500), $urandom_range(900, 100),
                        $urandom_range(300));
    endtask

    // everything offered, accepted and checked, then let the pipe settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_ticks.size() != 0 || sample_ch.valid ||
               expected_status.size() != 0 || hold_left != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // sample driver: predict on acceptance, then offer the next tick or idle
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_samples
        t_tick tk;
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                tk.voltage     = sample_ch.voltage_sample;
                tk.current     = sample_ch.current_sample;
                tk.temperature = sample_ch.temperature_sample;
                expected_status.push_back(predict_status(tk));
            end
            // payload only moves when nothing is held or it was just taken
            if (!sample_ch.valid || sample_ch.ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
                    tk = pending_ticks.pop_front();
                    sample_ch.valid              <= 1'b1;
                    sample_ch.voltage_sample     <= tk.voltage;
                    sample_ch.current_sample     <= tk.current;
                    sample_ch.temperature_sample <= tk.temperature;
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // status monitor: check each transaction against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic compare_field(string field, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_status
        t_result want;
        if (!i_rst_n) begin
            status_ch.ready <= 1'b0;
        end else begin
            if (status_ch.valid && status_ch.ready) begin
                if (expected_status.size() == 0) begin
                    $error("status transaction with no prediction pending");
                    mismatch_count++;
                end else begin
                    want = expected_status.pop_front();
                    compare_field("over_voltage", want.over_voltage, status_ch.over_voltage);
                    compare_field("under_voltage", want.under_voltage, status_ch.under_voltage);
                    compare_field("over_temperature", want.over_temperature,
                                  status_ch.over_temperature);
                    compare_field("over_current", want.over_current, status_ch.over_current);
                    compare_field("restrict_duty", want.restrict_duty, status_ch.restrict_duty);
                    compare_field("peak_current", want.peak_current, status_ch.peak_current);
                end
            end
            status_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // long hold-off of the status channel, to back the block up
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_served < hold_requests) begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL analog_fault_monitor_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        // known levels on every input from time zero, reset held low
        i_rst_n                      = 1'b0;
        i_cfg_we                     = 1'b0;
        i_cfg_addr                   = REG_VOLT_HIGH_TRIP;
        i_cfg_wdata                  = '0;
        sample_ch.valid              = 1'b0;
        sample_ch.voltage_sample     = '0;
        sample_ch.current_sample     = '0;
        sample_ch.temperature_sample = '0;
        status_ch.ready              = 1'b0;
        mismatch_count               = 0;
        cycle_count                  = 0;
        hold_requests                = 0;
        holds_served                 = 0;
        hold_left                    = 0;
        sender_gap_pct               = 0;
        receiver_stall_pct           = 0;
        volt_left                    = 0;
        temp_left                    = 0;
        curr_left                    = 0;
        thermal_plan                 = THERMAL_FREE;
        hold_limited_current         = 1'b0;
        peak_cap                     = 1400;

        // model state after reset
        thresholds[REG_VOLT_HIGH_TRIP]    = RST_VOLT_HIGH_TRIP;
        thresholds[REG_VOLT_HIGH_RELEASE] = RST_VOLT_HIGH_RELEASE;
        thresholds[REG_VOLT_LOW_TRIP]     = RST_VOLT_LOW_TRIP;
        thresholds[REG_VOLT_LOW_RELEASE]  = RST_VOLT_LOW_RELEASE;
        thresholds[REG_CURR_TRIP_LEVEL]   = RST_CURR_TRIP_LEVEL;
        thresholds[REG_CURR_LIMIT_LEVEL]  = RST_CURR_LIMIT_LEVEL;
        thresholds[REG_TEMP_LOW_TRIP]     = RST_TEMP_LOW_TRIP;
        thresholds[REG_CURRENT_OFFSET]    = RST_CURRENT_OFFSET;
        ov_alarm     = 1'b0;
        uv_alarm     = 1'b0;
        ot_alarm     = 1'b0;
        oc_alarm     = 1'b0;
        ov_run       = '0;
        uv_run       = '0;
        cold_run     = '0;
        warm_total   = '0;
        excess_accum = '0;
        peak_hold    = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks at the reset thresholds
        // field extremes, then values sitting exactly on each level
        push_tick(0, 0, 0);
        push_tick(FULL_SCALE, 0, FULL_SCALE);
        push_tick(RST_VOLT_HIGH_TRIP, RST_CURR_LIMIT_LEVEL, RST_TEMP_LOW_TRIP);
        push_tick(RST_VOLT_LOW_TRIP, RST_CURR_LIMIT_LEVEL + 1, TEMP_RELEASE);
        // eleven high-voltage ticks in a row set the over-voltage alarm,
        // while the current walks through limit, integration, trip,
        // hold above the limit and clear below it
        push_tick(RST_VOLT_HIGH_TRIP + 1, RST_CURR_TRIP_LEVEL, TEMP_RELEASE + 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, RST_CURR_TRIP_LEVEL + 1, TEMP_RELEASE + 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, RST_CURR_TRIP_LEVEL + BUDGET, TEMP_RELEASE + 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, RST_CURR_TRIP_LEVEL + 2, TEMP_RELEASE + 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, RST_CURR_TRIP_LEVEL, RST_TEMP_LOW_TRIP - 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, RST_CURR_LIMIT_LEVEL, RST_TEMP_LOW_TRIP - 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, 0, TEMP_RELEASE + 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, 1000, TEMP_RELEASE + 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, 1100, TEMP_RELEASE + 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, 1200, TEMP_RELEASE + 1);
        push_tick(RST_VOLT_HIGH_TRIP + 1, 1300, TEMP_RELEASE + 1);
        // on the release level the alarm holds, one below it clears
        push_tick(RST_VOLT_HIGH_RELEASE, 0, TEMP_RELEASE);
        push_tick(RST_VOLT_HIGH_RELEASE - 1, 0, TEMP_RELEASE);
        wait_idle();

        // no idling, with a long status hold-off so the block backs up
        hold_requests = hold_requests + 1;
        queue_random_ticks(200);
        wait_idle();

        // random thresholds, sender idling
        peak_cap       = 1800;
        sender_gap_pct = 54;
        load_random_thresholds();
        queue_random_ticks(150);
        wait_idle();

        // every register at zero, receiver stalling
        peak_cap           = 2200;
        sender_gap_pct     = 0;
        receiver_stall_pct = 54;
        load_thresholds(0, 0, 0, 0, 0, 0, 0, 0);
        queue_random_ticks(100);
        wait_idle();

        // every register at full scale, both sides idling
        peak_cap           = 2600;
        sender_gap_pct     = 22;
        receiver_stall_pct = 22;
        load_thresholds(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE,
                        FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE);
        queue_random_ticks(100);
        wait_idle();

        // trip level below the limit level, large offset
        peak_cap           = 3000;
        sender_gap_pct     = 54;
        receiver_stall_pct = 0;
        load_thresholds(2000, 1900, 600, 700, 300, 900, 450, $urandom_range(1500, 800));
        queue_random_ticks(100);
        wait_idle();

        // random thresholds again, receiver stalling
        peak_cap           = 3400;
        sender_gap_pct     = 0;
        receiver_stall_pct = 54;
        load_random_thresholds();
        queue_random_ticks(150);
        wait_idle();

        // temperature debounce at the reset thresholds:
        // a cold run broken by one tick on the trip level, a second cold
        // run, then mostly warm ticks
        peak_cap           = 3600;
        sender_gap_pct     = 22;
        receiver_stall_pct = 22;
        load_thresholds(RST_VOLT_HIGH_TRIP, RST_VOLT_HIGH_RELEASE, RST_VOLT_LOW_TRIP,
                        RST_VOLT_LOW_RELEASE, RST_CURR_TRIP_LEVEL, RST_CURR_LIMIT_LEVEL,
                        RST_TEMP_LOW_TRIP, RST_CURRENT_OFFSET);
        thermal_plan = THERMAL_COLD;
        queue_random_ticks(150);
        push_tick(pick_voltage(VB_ANY), pick_current(CB_NORMAL), RST_TEMP_LOW_TRIP);
        queue_random_ticks(100);
        thermal_plan = THERMAL_MOSTLY_WARM;
        queue_random_ticks(100);
        thermal_plan = THERMAL_FREE;
        queue_random_ticks(30);
        wait_idle();

        // accumulator driven negative: every corrected current above a
        // zero limit yet never above a full-scale trip
        peak_cap           = 3800;
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        load_thresholds(RST_VOLT_HIGH_TRIP, RST_VOLT_HIGH_RELEASE, RST_VOLT_LOW_TRIP,
                        RST_VOLT_LOW_RELEASE, FULL_SCALE, 0, RST_TEMP_LOW_TRIP, 0);
        hold_limited_current = 1'b1;
        queue_random_ticks(100);
        hold_limited_current = 1'b0;
        wait_idle();

        // climb back out of the negative range toward a trip,
        // full-scale current last
        peak_cap           = FULL_SCALE;
        sender_gap_pct     = 22;
        receiver_stall_pct = 22;
        load_thresholds(RST_VOLT_HIGH_TRIP, RST_VOLT_HIGH_RELEASE, RST_VOLT_LOW_TRIP,
                        RST_VOLT_LOW_RELEASE, 200, 0, RST_TEMP_LOW_TRIP, 0);
        queue_random_ticks(100);
        push_tick(FULL_SCALE, FULL_SCALE, 0);
        push_tick(0, FULL_SCALE, FULL_SCALE);
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("PASS analog_fault_monitor_unit");
        end else begin
            $display("FAIL analog_fault_monitor_unit");
        end
        $finish;
    end

endmodule
